@@ sv/fat_chain_allocator_unit_macros.svh @@
// Assertion macros for the file allocation table allocator.
// Used by fat_chain_allocator_unit; relies on clk and arst_n in the including module.
`ifndef FAT_CHAIN_ALLOCATOR_UNIT_MACROS_SVH
`define FAT_CHAIN_ALLOCATOR_UNIT_MACROS_SVH

// check an expression at every clock edge outside reset
`define FCA_ASSERT(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// check that an antecedent is followed in the next cycle by a consequent
`define FCA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/fca_pkg.sv @@
// Shared types and constants for the file allocation table allocator.
// No dependencies.
package fca_pkg;

	localparam int DEF_NUM_BLOCKS = 128;
	localparam int DEF_MAX_FILES  = 16;
	localparam int FIRST_BLOCK    = 2;
	localparam logic [6:0] LEN_MAX = 7'd127;

	// command codes
	localparam logic [1:0] CMD_CREATE   = 2'd0;
	localparam logic [1:0] CMD_INSERT   = 2'd1;
	localparam logic [1:0] CMD_READ_TBL = 2'd2;
	localparam logic [1:0] CMD_READ_DIR = 2'd3;

	// status codes
	localparam logic [2:0] STAT_OK       = 3'd0;
	localparam logic [2:0] STAT_NO_ROOM  = 3'd1;
	localparam logic [2:0] STAT_UNKNOWN  = 3'd2;
	localparam logic [2:0] STAT_BAD_LEN  = 3'd3;
	localparam logic [2:0] STAT_BAD_ADDR = 3'd4;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIR_CHK,
		ST_TBL_CHK,
		ST_WALK_CHK,
		ST_SCAN,
		ST_SCAN_CHK,
		ST_CR_LINK,
		ST_CR_NEXT,
		ST_CR_DIR,
		ST_INS_WR1,
		ST_INS_WR2,
		ST_EMIT
	} fca_state_t;

endpackage

@@ sv/fca_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module fca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/fat_chain_allocator_unit.sv @@
// File allocation table allocator: link table and directory in RAM, command sequencer.
// Depends on fca_pkg, fca_ram and fat_chain_allocator_unit_macros.svh.
//
// One command is taken at a time and gives one result item. Reads of a table or
// directory entry go through the registered RAM read. Create scans table entries for
// free blocks (at most NUM_BLOCKS) and links each block found; insert walks the chain
// to its position and then scans for a free block. The run time is set by the single
// read port of the link table, touched once per scanned or walked entry. Errors are
// reported with no state change. The link table resets through per-entry valid
// bits; no clearing pass.
`include "fat_chain_allocator_unit_macros.svh"

module fat_chain_allocator_unit
	import fca_pkg::*;
#(
	parameter int NUM_BLOCKS = DEF_NUM_BLOCKS,
	parameter int MAX_FILES  = DEF_MAX_FILES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        command,
	input  logic [3:0]        file_index,
	input  logic [6:0]        amount,
	input  logic [6:0]        block_address,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        status,
	output logic [3:0]        result_file,
	output logic [6:0]        start_block,
	output logic [6:0]        file_length,
	output logic signed [7:0] entry_value,
	output logic [6:0]        free_blocks
);

	localparam int BW  = $clog2(NUM_BLOCKS);
	localparam int PW  = BW + 1;
	localparam int EW  = BW + 1;
	localparam int DW  = $clog2(MAX_FILES);
	localparam int CW  = $clog2(MAX_FILES + 1);
	localparam int FIW = (DW > 4) ? DW : 4;
	localparam int AXW = (BW > 7) ? BW : 7;
	localparam int DRW = BW + 7;

	localparam logic signed [EW-1:0] ENTRY_END  = -EW'(1);
	localparam logic signed [EW-1:0] ENTRY_RSVD = -EW'(2);

	fca_state_t state_q, state_d;

	// command registers
	logic [1:0]  cmd_q;
	logic [FIW-1:0] fi_q;
	logic [6:0]  amt_q;
	logic [6:0]  cnt_q;
	logic [PW-1:0] ptr_q;
	logic [BW-1:0] prev_q, nb_q, pos_q, start_q, dstart_q;
	logic [6:0]  dlen_q;
	logic [CW-1:0] fc_q;
	logic [BW-1:0] free_q;

	// pending result
	logic [2:0] res_status_q;
	logic [3:0] res_file_q;
	logic [6:0] res_start_q, res_len_q;
	logic [7:0] res_entry_q;

	// output register
	logic       out_valid_q;
	logic [2:0] out_status_q;
	logic [3:0] out_file_q;
	logic [6:0] out_start_q, out_len_q, out_free_q;
	logic [7:0] out_entry_q;

	// link table port
	logic          lk_re, lk_we;
	logic [BW-1:0] lk_raddr, lk_waddr;
	logic [EW-1:0] lk_wdata, lk_q;
	logic [NUM_BLOCKS-1:0] vld_q;
	logic          rd_vld_q;
	logic [BW-1:0] rd_addr_q;
	logic signed [EW-1:0] lk_val;

	// directory port
	logic          dir_re, dir_we;
	logic [DW-1:0] dir_raddr, dir_waddr;
	logic [DRW-1:0] dir_wdata, dir_q;

	logic [FIW-1:0] fi_ext;
	logic [AXW-1:0] addr_ext;
	logic signed [EW+7:0] entry_ext;
	logic          in_acc;
	logic          dir_known, walk_bad, scan_free, scan_end;

	assign in_acc   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign fi_ext   = FIW'(file_index);
	assign addr_ext = AXW'(block_address);

	fca_ram #(.WIDTH(EW), .DEPTH(NUM_BLOCKS)) u_link_ram (
		.clk(clk), .we(lk_we), .waddr(lk_waddr), .wdata(lk_wdata),
		.re(lk_re), .raddr(lk_raddr), .rdata(lk_q)
	);

	fca_ram #(.WIDTH(DRW), .DEPTH(MAX_FILES)) u_dir_ram (
		.clk(clk), .we(dir_we), .waddr(dir_waddr), .wdata(dir_wdata),
		.re(dir_re), .raddr(dir_raddr), .rdata(dir_q)
	);

	// table entry as read: never-written entries show their reset value
	always_comb begin
		if (rd_vld_q) begin
			lk_val = lk_q;
		end else if (rd_addr_q == BW'(0)) begin
			lk_val = ENTRY_RSVD;
		end else if (rd_addr_q == BW'(1)) begin
			lk_val = ENTRY_END;
		end else begin
			lk_val = '0;
		end
	end

	assign entry_ext = (EW + 8)'(lk_val);
	assign walk_bad  = lk_val[EW-1] || (lk_val == '0)
		|| ({1'b0, lk_val[BW-1:0]} >= PW'(NUM_BLOCKS));
	assign scan_free = (lk_val == '0);
	assign scan_end  = (32'(ptr_q) + 1 >= NUM_BLOCKS);
	assign dir_known = (32'(fi_ext) < 32'(fc_q));

	// track read address and valid bit alongside the RAM read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (lk_we) begin
			vld_q[lk_waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (lk_re) begin
			rd_vld_q  <= vld_q[lk_raddr];
			rd_addr_q <= lk_raddr;
		end
	end

	// next state and memory control
	always_comb begin
		state_d   = state_q;
		lk_re     = 1'b0;
		lk_raddr  = '0;
		lk_we     = 1'b0;
		lk_waddr  = '0;
		lk_wdata  = '0;
		dir_re    = 1'b0;
		dir_raddr = fi_ext[DW-1:0];
		dir_we    = 1'b0;
		dir_waddr = '0;
		dir_wdata = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					case (command)
						CMD_CREATE: begin
							if (amount == 7'd0 || 32'(fc_q) >= MAX_FILES
								|| 32'(amount) > 32'(free_q)) begin
								state_d = ST_EMIT;
							end else begin
								state_d = ST_SCAN;
							end
						end
						CMD_READ_TBL: begin
							if (32'(block_address) >= NUM_BLOCKS) begin
								state_d = ST_EMIT;
							end else begin
								lk_re    = 1'b1;
								lk_raddr = addr_ext[BW-1:0];
								state_d  = ST_TBL_CHK;
							end
						end
						default: begin
							if (!dir_known) begin
								state_d = ST_EMIT;
							end else begin
								dir_re  = 1'b1;
								state_d = ST_DIR_CHK;
							end
						end
					endcase
				end
			end
			ST_TBL_CHK: begin
				state_d = ST_EMIT;
			end
			ST_DIR_CHK: begin
				if (cmd_q == CMD_READ_DIR) begin
					state_d = ST_EMIT;
				end else if (amt_q == 7'd0 || amt_q > dir_q[6:0]) begin
					state_d = ST_EMIT;
				end else if (free_q == '0 || dir_q[6:0] >= LEN_MAX) begin
					state_d = ST_EMIT;
				end else if (amt_q > 7'd1) begin
					lk_re    = 1'b1;
					lk_raddr = dir_q[DRW-1:7];
					state_d  = ST_WALK_CHK;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_WALK_CHK: begin
				if (walk_bad || cnt_q + 7'd1 >= amt_q) begin
					state_d = ST_SCAN;
				end else begin
					lk_re    = 1'b1;
					lk_raddr = lk_val[BW-1:0];
				end
			end
			ST_SCAN: begin
				if (32'(ptr_q) >= NUM_BLOCKS) begin
					state_d = (cmd_q == CMD_CREATE) ? ST_CR_DIR : ST_EMIT;
				end else begin
					lk_re    = 1'b1;
					lk_raddr = ptr_q[BW-1:0];
					state_d  = ST_SCAN_CHK;
				end
			end
			ST_SCAN_CHK: begin
				if (scan_free) begin
					if (cmd_q == CMD_CREATE) begin
						lk_we    = 1'b1;
						lk_waddr = ptr_q[BW-1:0];
						lk_wdata = ENTRY_END;
						state_d  = (cnt_q == 7'd0) ? ST_CR_NEXT : ST_CR_LINK;
					end else begin
						lk_re    = 1'b1;
						lk_raddr = pos_q;
						state_d  = ST_INS_WR1;
					end
				end else if (scan_end) begin
					state_d = (cmd_q == CMD_CREATE) ? ST_CR_DIR : ST_EMIT;
				end else begin
					lk_re    = 1'b1;
					lk_raddr = BW'(ptr_q + PW'(1));
				end
			end
			ST_CR_LINK: begin
				lk_we    = 1'b1;
				lk_waddr = prev_q;
				lk_wdata = {1'b0, nb_q};
				state_d  = ST_CR_NEXT;
			end
			ST_CR_NEXT: begin
				state_d = (cnt_q == amt_q) ? ST_CR_DIR : ST_SCAN;
			end
			ST_CR_DIR: begin
				dir_we    = 1'b1;
				dir_waddr = fc_q[DW-1:0];
				dir_wdata = {start_q, amt_q};
				state_d   = ST_EMIT;
			end
			ST_INS_WR1: begin
				lk_we    = 1'b1;
				lk_waddr = nb_q;
				lk_wdata = lk_val;
				state_d  = ST_INS_WR2;
			end
			ST_INS_WR2: begin
				lk_we     = 1'b1;
				lk_waddr  = pos_q;
				lk_wdata  = {1'b0, nb_q};
				dir_we    = 1'b1;
				dir_waddr = fi_q[DW-1:0];
				dir_wdata = {dstart_q, dlen_q + 7'd1};
				state_d   = ST_EMIT;
			end
			ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// directory counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q   <= '0;
			free_q <= BW'(NUM_BLOCKS - FIRST_BLOCK);
		end else if (state_q == ST_CR_DIR) begin
			fc_q   <= fc_q + CW'(1);
			free_q <= free_q - BW'(amt_q);
		end else if (state_q == ST_INS_WR2) begin
			free_q <= free_q - BW'(1);
		end
	end

	// command datapath and pending result
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cmd_q        <= command;
				fi_q         <= fi_ext;
				amt_q        <= amount;
				cnt_q        <= '0;
				ptr_q        <= PW'(FIRST_BLOCK);
				res_status_q <= STAT_OK;
				res_file_q   <= '0;
				res_start_q  <= '0;
				res_len_q    <= '0;
				res_entry_q  <= '0;
				case (command)
					CMD_CREATE: begin
						if (amount == 7'd0) begin
							res_status_q <= STAT_BAD_LEN;
						end else if (32'(fc_q) >= MAX_FILES
							|| 32'(amount) > 32'(free_q)) begin
							res_status_q <= STAT_NO_ROOM;
						end
					end
					CMD_READ_TBL: begin
						if (32'(block_address) >= NUM_BLOCKS) begin
							res_status_q <= STAT_BAD_ADDR;
						end
					end
					default: begin
						if (!dir_known) begin
							res_status_q <= STAT_UNKNOWN;
						end
					end
				endcase
			end
			ST_TBL_CHK: begin
				res_entry_q <= entry_ext[7:0];
			end
			ST_DIR_CHK: begin
				dstart_q <= dir_q[DRW-1:7];
				dlen_q   <= dir_q[6:0];
				pos_q    <= dir_q[DRW-1:7];
				cnt_q    <= 7'd1;
				if (cmd_q == CMD_READ_DIR) begin
					res_file_q  <= fi_q[3:0];
					res_start_q <= 7'(dir_q[DRW-1:7]);
					res_len_q   <= dir_q[6:0];
				end else if (amt_q == 7'd0 || amt_q > dir_q[6:0]) begin
					res_status_q <= STAT_BAD_LEN;
				end else if (free_q == '0 || dir_q[6:0] >= LEN_MAX) begin
					res_status_q <= STAT_NO_ROOM;
				end
			end
			ST_WALK_CHK: begin
				if (!walk_bad) begin
					pos_q <= lk_val[BW-1:0];
					cnt_q <= cnt_q + 7'd1;
				end
			end
			ST_SCAN: begin
				if (32'(ptr_q) >= NUM_BLOCKS && cmd_q != CMD_CREATE) begin
					res_status_q <= STAT_NO_ROOM;
				end
			end
			ST_SCAN_CHK: begin
				if (scan_free) begin
					nb_q <= ptr_q[BW-1:0];
					if (cmd_q == CMD_CREATE) begin
						cnt_q <= cnt_q + 7'd1;
						if (cnt_q == 7'd0) begin
							start_q <= ptr_q[BW-1:0];
							prev_q  <= ptr_q[BW-1:0];
						end
					end
				end else if (scan_end) begin
					if (cmd_q != CMD_CREATE) begin
						res_status_q <= STAT_NO_ROOM;
					end
				end else begin
					ptr_q <= ptr_q + PW'(1);
				end
			end
			ST_CR_LINK: begin
				prev_q <= nb_q;
			end
			ST_CR_NEXT: begin
				ptr_q <= ptr_q + PW'(1);
			end
			ST_CR_DIR: begin
				res_file_q  <= 4'(fc_q);
				res_start_q <= 7'(start_q);
				res_len_q   <= amt_q;
			end
			ST_INS_WR2: begin
				res_file_q  <= fi_q[3:0];
				res_start_q <= 7'(dstart_q);
				res_len_q   <= dlen_q + 7'd1;
			end
			default: begin
			end
		endcase
	end

	// output register: load the result, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && (!out_valid_q || out_ready)) begin
			out_status_q <= res_status_q;
			out_file_q   <= res_file_q;
			out_start_q  <= res_start_q;
			out_len_q    <= res_len_q;
			out_entry_q  <= res_entry_q;
			out_free_q   <= 7'(free_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign result_file = out_file_q;
	assign start_block = out_start_q;
	assign file_length = out_len_q;
	assign entry_value = out_entry_q;
	assign free_blocks = out_free_q;

	`FCA_ASSERT(a_free_bound, 32'(free_q) <= NUM_BLOCKS - FIRST_BLOCK, "free count overflow")
	`FCA_ASSERT(a_files_bound, 32'(fc_q) <= MAX_FILES, "file count overflow")
	`FCA_ASSERT(a_no_sys_write, !lk_we || 32'(lk_waddr) >= FIRST_BLOCK, "write to system block")
	`FCA_ASSERT(a_rw_clash, !(lk_we && lk_re) || lk_waddr != lk_raddr, "link read/write clash")
	`FCA_ASSERT_NEXT(a_busy, in_acc, state_q != ST_IDLE, "accepted item left sequencer idle")

endmodule

@@ tb/fat_chain_allocator_unit_tb.sv @@
// Testbench for fat_chain_allocator_unit: directed and random commands against a
// cycle-free model of the allocation table. Depends on fca_pkg and the block's RTL.
module fat_chain_allocator_unit_tb;
	import fca_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NBLK = DEF_NUM_BLOCKS;
	localparam int NFILE = DEF_MAX_FILES;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct {
		logic [1:0] command;
		logic [3:0] file_index;
		logic [6:0] amount;
		logic [6:0] block_address;
		bit         drain;
	} fat_cmd_t;

	typedef struct {
		logic [2:0]        status;
		logic [3:0]        result_file;
		logic [6:0]        start_block;
		logic [6:0]        file_length;
		logic signed [7:0] entry_value;
		logic [6:0]        free_blocks;
	} fat_res_t;

	typedef struct {
		int tbl [NBLK];
		int dstart [NFILE];
		int dlen [NFILE];
		int files;
		int free_n;
	} fat_state_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [1:0] command = '0;
	logic [3:0] file_index = '0;
	logic [6:0] amount = '0;
	logic [6:0] block_address = '0;
	logic out_valid;
	logic out_ready = 0;
	logic [2:0] status;
	logic [3:0] result_file;
	logic [6:0] start_block;
	logic [6:0] file_length;
	logic signed [7:0] entry_value;
	logic [6:0] free_blocks;

	fat_cmd_t pending_cmds[$];
	fat_res_t expected_results[$];
	fat_state_t table_model;
	fat_state_t plan_model;
	int errors = 0;
	int cycles = 0;
	bit stim_done = 0;

	fat_chain_allocator_unit dut (.*);

	always #5 clk = ~clk;

	// reset the model to the power-up table
	function automatic void fat_reset(ref fat_state_t s);
		foreach (s.tbl[i]) s.tbl[i] = 0;
		foreach (s.dstart[i]) begin
			s.dstart[i] = 0;
			s.dlen[i] = 0;
		end
		s.tbl[0] = -2;
		s.tbl[1] = -1;
		s.files = 0;
		s.free_n = NBLK - 2;
	endfunction

	function automatic int fat_lowest(ref fat_state_t s);
		for (int b = FIRST_BLOCK; b < NBLK; b++)
			if (s.tbl[b] == 0) return b;
		return NBLK;
	endfunction

	// apply one command to the model and form its result
	function automatic void fat_exec(ref fat_state_t s, input fat_cmd_t c, output fat_res_t r);
		int prev, nb, pos, fi, amt;
		r = '{default: '0};
		fi = int'(c.file_index);
		amt = int'(c.amount);
		case (c.command)
			CMD_CREATE: begin
				if (amt == 0) r.status = STAT_BAD_LEN;
				else if (s.files >= NFILE || amt > s.free_n) r.status = STAT_NO_ROOM;
				else begin
					prev = fat_lowest(s);
					s.tbl[prev] = -1;
					r.start_block = 7'(prev);
					for (int i = 1; i < amt; i++) begin
						nb = fat_lowest(s);
						if (nb >= NBLK) break;
						s.tbl[prev] = nb;
						s.tbl[nb] = -1;
						prev = nb;
					end
					r.result_file = 4'(s.files);
					s.dstart[s.files] = int'(r.start_block);
					s.dlen[s.files] = amt;
					r.file_length = 7'(amt);
					s.files++;
					s.free_n -= amt;
				end
			end
			CMD_INSERT: begin
				if (fi >= s.files) r.status = STAT_UNKNOWN;
				else if (amt == 0 || amt > s.dlen[fi]) r.status = STAT_BAD_LEN;
				else if (s.free_n == 0 || s.dlen[fi] >= LEN_MAX) r.status = STAT_NO_ROOM;
				else begin
					pos = s.dstart[fi];
					for (int i = 1; i < amt; i++) begin
						if (s.tbl[pos] <= 0 || s.tbl[pos] >= NBLK) break;
						pos = s.tbl[pos];
					end
					nb = fat_lowest(s);
					if (nb >= NBLK) r.status = STAT_NO_ROOM;
					else begin
						s.tbl[nb] = s.tbl[pos];
						s.tbl[pos] = nb;
						s.dlen[fi]++;
						s.free_n--;
						r.result_file = 4'(fi);
						r.start_block = 7'(s.dstart[fi]);
						r.file_length = 7'(s.dlen[fi]);
					end
				end
			end
			CMD_READ_TBL: begin
				if (c.block_address >= NBLK) r.status = STAT_BAD_ADDR;
				else r.entry_value = 8'(s.tbl[c.block_address]);
			end
			default: begin
				if (fi >= s.files) r.status = STAT_UNKNOWN;
				else begin
					r.result_file = 4'(fi);
					r.start_block = 7'(s.dstart[fi]);
					r.file_length = 7'(s.dlen[fi]);
				end
			end
		endcase
		r.free_blocks = 7'(s.free_n);
	endfunction

	// queue one command and track it in the planning model
	task automatic plan(input logic [1:0] cm, input int fi, input int amt, input int addr,
			input bit drain = 0);
		fat_cmd_t c;
		fat_res_t r;
		c.command = cm;
		c.file_index = 4'(fi);
		c.amount = 7'(amt);
		c.block_address = 7'(addr);
		c.drain = drain;
		fat_exec(plan_model, c, r);
		pending_cmds.push_back(c);
	endtask

	// sender: bursts and gaps; hold a draining item until all results are in
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		fat_cmd_t c;
		fat_res_t r;
		bit take;
		if (!arst_n) begin
			in_valid <= 0;
		end else begin
			take = in_valid && in_ready;
			if (take) begin
				c = pending_cmds.pop_front();
				fat_exec(table_model, c, r);
				expected_results.push_back(r);
			end
			if (in_valid && !take) begin
				// hold the item until accepted
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 0;
			end else if (pending_cmds.size() > 0 && !(pending_cmds[0].drain &&
					(expected_results.size() > 0 || take))) begin
				in_valid <= 1;
				command <= pending_cmds[0].command;
				file_index <= pending_cmds[0].file_index;
				amount <= pending_cmds[0].amount;
				block_address <= pending_cmds[0].block_address;
				if (burst_left > 0) burst_left <= burst_left - 1;
				else begin
					burst_left <= int'($urandom_range(0, 12));
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 :
						int'($urandom_range(0, 6));
				end
			end else begin
				in_valid <= 0;
			end
		end
	end

	// receiver: stall pattern rotates through three phases: always ready, a fixed pattern, random
	logic [7:0] stall_pat = 8'b1011_0010;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 0;
		end else begin
			stall_pat <= {stall_pat[6:0], stall_pat[7]};
			case ((cycles / 3000) % 3)
				0: out_ready <= 1;
				1: out_ready <= stall_pat[0];
				default: out_ready <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// compare each result with the oldest expectation
	always @(posedge clk) begin
		fat_res_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result item");
				errors++;
			end else begin
				e = expected_results.pop_front();
				if (status !== e.status) begin
					$error("status exp %0d got %0d", e.status, status);
					errors++;
				end
				if (result_file !== e.result_file) begin
					$error("result_file exp %0d got %0d", e.result_file, result_file);
					errors++;
				end
				if (start_block !== e.start_block) begin
					$error("start_block exp %0d got %0d", e.start_block, start_block);
					errors++;
				end
				if (file_length !== e.file_length) begin
					$error("file_length exp %0d got %0d", e.file_length, file_length);
					errors++;
				end
				if (entry_value !== e.entry_value) begin
					$error("entry_value exp %0d got %0d", e.entry_value, entry_value);
					errors++;
				end
				if (free_blocks !== e.free_blocks) begin
					$error("free_blocks exp %0d got %0d", e.free_blocks, free_blocks);
					errors++;
				end
			end
		end
	end

	// timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int k, fi;
		fat_reset(table_model);
		fat_reset(plan_model);

		// directed: error paths, extremes, reads of reset entries
		plan(CMD_CREATE, 0, 0, 0);
		plan(CMD_CREATE, 0, 127, 0);
		plan(CMD_INSERT, 15, 1, 0);
		plan(CMD_READ_DIR, 15, 0, 0);
		plan(CMD_READ_TBL, 0, 0, 0);
		plan(CMD_READ_TBL, 0, 0, 1);
		plan(CMD_READ_TBL, 0, 0, 127);
		plan(CMD_CREATE, 0, 3, 0);
		plan(CMD_INSERT, 0, 0, 0);
		plan(CMD_INSERT, 0, 4, 0);
		plan(CMD_INSERT, 0, 1, 0);
		plan(CMD_INSERT, 0, 4, 0);
		plan(CMD_INSERT, 0, 2, 0);
		plan(CMD_CREATE, 0, 1, 0);
		plan(CMD_READ_DIR, 0, 0, 0);
		plan(CMD_READ_DIR, 1, 0, 0);
		plan(CMD_READ_TBL, 0, 0, 2);
		plan(CMD_READ_TBL, 0, 0, 3);
		plan(CMD_READ_TBL, 0, 0, 5);

		// random: small creates and in-range inserts mostly, noise the rest
		for (int n = 0; n < 780; n++) begin
			k = int'($urandom_range(0, 99));
			fi = (plan_model.files > 0) ? int'($urandom_range(0, plan_model.files - 1)) : 0;
			if (k < 20)
				plan(CMD_CREATE, int'($urandom), ($urandom_range(0, 7) == 0) ?
					int'($urandom_range(1, 20)) : int'($urandom_range(1, 3)),
					int'($urandom), n == 400);
			else if (k < 50 && plan_model.files > 0)
				plan(CMD_INSERT, fi, int'($urandom_range(1, plan_model.dlen[fi])),
					int'($urandom), n == 400);
			else if (k < 70)
				plan(CMD_READ_TBL, int'($urandom), int'($urandom), int'($urandom), n == 400);
			else if (k < 85)
				plan(CMD_READ_DIR, int'($urandom), int'($urandom), int'($urandom), n == 400);
			else
				plan(2'($urandom), int'($urandom), int'($urandom), int'($urandom),
					n == 400);
		end

		// use up the rest, then hit the no-room paths
		if (plan_model.free_n > 0)
			plan(CMD_CREATE, 0, plan_model.free_n, 0, 1);
		plan(CMD_INSERT, 0, 1, 0);
		plan(CMD_CREATE, 0, 1, 0);
		for (int a = 0; a < 8; a++)
			plan(CMD_READ_TBL, 0, 0, int'($urandom));

		repeat (5) @(posedge clk);
		arst_n <= 1;

		wait (pending_cmds.size() == 0 && expected_results.size() == 0);
		repeat (400) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

@@ fat_chain_allocator_unit.f @@
+incdir+sv
sv/fca_pkg.sv
sv/fca_ram.sv
sv/fat_chain_allocator_unit.sv
tb/fat_chain_allocator_unit_tb.sv
